// File: design/calendar_date_add_days_core_defines.svh
// Assertion macros shared by the checker.
`ifndef CALENDAR_DATE_ADD_DAYS_CORE_DEFINES_SVH
`define CALENDAR_DATE_ADD_DAYS_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CDAD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CDAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/cdad_pkg.sv
package cdad_pkg;

	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned COUNT_W  = 21;
	localparam int unsigned TOTAL_W  = 22;
	localparam int unsigned QUOT_W   = 12;
	localparam int unsigned RYEAR_W  = 14;
	localparam int unsigned DOY_W    = 9;
	localparam int unsigned CMP_W    = 17;

	localparam int unsigned DAYS_COMMON    = 365;
	localparam int unsigned FEB_COMMON     = 28;
	localparam int unsigned LEAP_PERIOD    = 4;
	localparam int unsigned DAYS_PER_CYCLE = LEAP_PERIOD * DAYS_COMMON + 1;

	localparam int unsigned RECIP_SHIFT = 33;
	localparam int unsigned RECIP_W     = 23;
	localparam logic [RECIP_W-1:0] CYCLE_RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DAYS_PER_CYCLE) - 64'd1) / 64'(DAYS_PER_CYCLE));

	localparam logic CMD_ADD_OFFSET = 1'b0;
	localparam logic CMD_ADD_DATE   = 1'b1;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;

	typedef struct packed {
		logic [RYEAR_W-1:0] year;
		logic [DOY_W-1:0]   doy;
		logic               leap;
		logic               overflow;
	} year_info_t;

	// Days before the start of a month in a common year; index 0 is January.
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx);
		logic [DOY_W-1:0] days;
		unique case (idx)
			4'd0:    days = 9'd0;
			4'd1:    days = 9'd31;
			4'd2:    days = 9'(31 + FEB_COMMON);
			4'd3:    days = 9'(62 + FEB_COMMON);
			4'd4:    days = 9'(92 + FEB_COMMON);
			4'd5:    days = 9'(123 + FEB_COMMON);
			4'd6:    days = 9'(153 + FEB_COMMON);
			4'd7:    days = 9'(184 + FEB_COMMON);
			4'd8:    days = 9'(215 + FEB_COMMON);
			4'd9:    days = 9'(245 + FEB_COMMON);
			4'd10:   days = 9'(276 + FEB_COMMON);
			4'd11:   days = 9'(306 + FEB_COMMON);
			4'd12:   days = 9'(DAYS_COMMON);
			default: days = 9'(DAYS_COMMON);
		endcase
		return days;
	endfunction

endpackage

// File: design/cdad_to_count.sv
module cdad_to_count (
	input  logic [cdad_pkg::DAY_W-1:0]   day,
	input  logic [cdad_pkg::MONTH_W-1:0] month,
	input  logic [cdad_pkg::YEAR_W-1:0]  year,
	output logic [cdad_pkg::COUNT_W-1:0] count
);
	import cdad_pkg::*;

	logic [MONTH_W-1:0] mon;
	logic [YEAR_W-1:0]  yr;
	logic [YEAR_W-1:0]  prev;
	logic               leap_bump;

	always_comb begin
		if (month < MONTH_JAN) begin
			mon = MONTH_JAN;
		end else if (month > MONTH_DEC) begin
			mon = MONTH_DEC;
		end else begin
			mon = month;
		end
		yr = (year == '0) ? YEAR_W'(1) : year;
		prev = yr - YEAR_W'(1);
		leap_bump = (yr[1:0] == 2'b00) && (mon > MONTH_FEB);
		count = COUNT_W'(prev) * COUNT_W'(DAYS_COMMON)
			+ COUNT_W'(prev >> 2)
			+ COUNT_W'(month_start(mon - MONTH_JAN))
			+ COUNT_W'(leap_bump)
			+ COUNT_W'(day);
	end

endmodule

// File: design/cdad_split.sv
module cdad_split #(
	parameter int unsigned MAX_YEAR = 4095
) (
	input  logic [cdad_pkg::TOTAL_W-1:0] n0,
	input  logic [cdad_pkg::QUOT_W-1:0]  quot,
	output cdad_pkg::year_info_t         info
);
	import cdad_pkg::*;

	logic [10:0]  rem;
	logic [1:0]   yoff;
	logic [RYEAR_W-1:0] yr;

	always_comb begin
		rem = 11'(n0 - TOTAL_W'(quot) * TOTAL_W'(DAYS_PER_CYCLE));
		yoff = 2'(rem >= 11'(DAYS_COMMON))
			+ 2'(rem >= 11'(2 * DAYS_COMMON))
			+ 2'(rem >= 11'(3 * DAYS_COMMON));
		yr = {quot, 2'b00} + RYEAR_W'(yoff) + RYEAR_W'(1);
		info.year = yr;
		info.doy = DOY_W'(rem - 11'(yoff) * 11'(DAYS_COMMON));
		info.leap = (yoff == 2'd3);
		info.overflow = CMP_W'(yr) > CMP_W'(MAX_YEAR);
	end

endmodule

// File: design/cdad_month.sv
module cdad_month #(
	parameter int unsigned MAX_YEAR = 4095
) (
	input  cdad_pkg::year_info_t         info,
	output logic [cdad_pkg::DAY_W-1:0]   day,
	output logic [cdad_pkg::MONTH_W-1:0] month,
	output logic [cdad_pkg::YEAR_W-1:0]  year,
	output logic                         overflow
);
	import cdad_pkg::*;

	logic [MONTH_W-1:0] idx;
	logic [DOY_W-1:0]   bound;
	logic [DOY_W-1:0]   start;

	always_comb begin
		idx = '0;
		for (int i = 0; i < 11; i++) begin
			bound = month_start(MONTH_W'(i + 1)) + DOY_W'(info.leap && (i >= 1));
			idx = idx + MONTH_W'(info.doy >= bound);
		end
		start = month_start(idx) + DOY_W'(info.leap && (idx >= MONTH_FEB));
		overflow = info.overflow;
		if (info.overflow) begin
			day = DAY_LAST;
			month = MONTH_DEC;
			year = YEAR_W'(MAX_YEAR);
		end else begin
			day = DAY_W'(info.doy - start + DOY_W'(1));
			month = idx + MONTH_JAN;
			year = info.year[YEAR_W-1:0];
		end
	end

endmodule

// File: design/calendar_date_add_days_core.sv
// Channel  Valid      Stall      Word
// request  req_valid  req_stall  command, base_*, offset_days, other_*
// result   rsp_valid  rsp_stall  result_day, result_month, result_year, overflow
//
// An accepted word moves through stages s1 to s5 into the result register.
// A new word is accepted in every cycle while req_stall is low; there are five pipeline stages.
// Reset clears the stage valid bits and nothing else.
// A stall on the result side holds the result stage and each full stage right behind it,
// so bubbles close up, and it reaches req_stall only once every stage is full.
module calendar_date_add_days_core #(
	parameter int unsigned MAX_YEAR = 4095
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            command,
	input  logic [cdad_pkg::DAY_W-1:0]      base_day,
	input  logic [cdad_pkg::MONTH_W-1:0]    base_month,
	input  logic [cdad_pkg::YEAR_W-1:0]     base_year,
	input  logic [cdad_pkg::OFFSET_W-1:0]   offset_days,
	input  logic [cdad_pkg::DAY_W-1:0]      other_day,
	input  logic [cdad_pkg::MONTH_W-1:0]    other_month,
	input  logic [cdad_pkg::YEAR_W-1:0]     other_year,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [cdad_pkg::DAY_W-1:0]      result_day,
	output logic [cdad_pkg::MONTH_W-1:0]    result_month,
	output logic [cdad_pkg::YEAR_W-1:0]     result_year,
	output logic                            overflow
);
	import cdad_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	logic [COUNT_W-1:0] count_a, count_b;
	logic [COUNT_W-1:0] count_a_s1, addend_s1;
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] n0_s2;
	logic [TOTAL_W+RECIP_W-1:0] prod;
	logic [TOTAL_W-1:0] n0_s3;
	logic [QUOT_W-1:0]  quot_s3;
	year_info_t         info;
	year_info_t         info_s4;
	logic [DAY_W-1:0]   day_c;
	logic [MONTH_W-1:0] month_c;
	logic [YEAR_W-1:0]  year_c;
	logic               ovf_c;
	logic [DAY_W-1:0]   day_s5;
	logic [MONTH_W-1:0] month_s5;
	logic [YEAR_W-1:0]  year_s5;
	logic               ovf_s5;

	assign adv5 = !valid_s5 || !rsp_stall;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign req_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= req_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
		end
	end

	cdad_to_count u_count_base (
		.day   (base_day),
		.month (base_month),
		.year  (base_year),
		.count (count_a)
	);

	cdad_to_count u_count_other (
		.day   (other_day),
		.month (other_month),
		.year  (other_year),
		.count (count_b)
	);

	always_ff @(posedge clk) begin
		if (adv1 && req_valid) begin
			count_a_s1 <= count_a;
			addend_s1 <= (command == CMD_ADD_DATE) ? count_b : COUNT_W'(offset_days);
		end
	end

	assign total = TOTAL_W'(count_a_s1) + TOTAL_W'(addend_s1);

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			n0_s2 <= (total == '0) ? '0 : total - TOTAL_W'(1);
		end
	end

	assign prod = (TOTAL_W + RECIP_W)'(n0_s2) * (TOTAL_W + RECIP_W)'(CYCLE_RECIP);

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			n0_s3 <= n0_s2;
			quot_s3 <= prod[RECIP_SHIFT +: QUOT_W];
		end
	end

	cdad_split #(.MAX_YEAR(MAX_YEAR)) u_split (
		.n0   (n0_s3),
		.quot (quot_s3),
		.info (info)
	);

	always_ff @(posedge clk) begin
		if (adv4 && valid_s3) begin
			info_s4 <= info;
		end
	end

	cdad_month #(.MAX_YEAR(MAX_YEAR)) u_month (
		.info     (info_s4),
		.day      (day_c),
		.month    (month_c),
		.year     (year_c),
		.overflow (ovf_c)
	);

	always_ff @(posedge clk) begin
		if (adv5 && valid_s4) begin
			day_s5 <= day_c;
			month_s5 <= month_c;
			year_s5 <= year_c;
			ovf_s5 <= ovf_c;
		end
	end

	assign rsp_valid = valid_s5;
	assign result_day = day_s5;
	assign result_month = month_s5;
	assign result_year = year_s5;
	assign overflow = ovf_s5;

endmodule

// File: design/cdad_checker.sv
`include "calendar_date_add_days_core_defines.svh"

module cdad_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [cdad_pkg::DAY_W-1:0]    result_day,
	input logic [cdad_pkg::MONTH_W-1:0]  result_month,
	input logic [cdad_pkg::YEAR_W-1:0]   result_year,
	input logic                          overflow
);
	import cdad_pkg::*;

	`CDAD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(result_day) && $stable(result_month) && $stable(result_year) && $stable(overflow), "Stalled result word changed.")
	`CDAD_ASSERT_SAME(a_ovf_sat, rsp_valid && overflow, result_day == DAY_LAST && result_month == MONTH_DEC, "Overflow result is not the last day of December.")
	`CDAD_ASSERT_SAME(a_date_range, rsp_valid, result_month >= MONTH_JAN && result_month <= MONTH_DEC && result_day != '0, "Result date is out of range.")
	`CDAD_ASSERT_SAME(a_no_idle_stall, !rsp_stall, !req_stall, "Request stalled while the result side is free.")

endmodule

bind calendar_date_add_days_core cdad_checker u_cdad_checker (.*);

// File: sim/tb_calendar_date_add_days_core.sv
module tb_calendar_date_add_days_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cdad_pkg::*;

	localparam int unsigned MAX_YEAR = 4095;
	localparam int unsigned IDLE_PCT = 27;
	localparam int unsigned TIMEOUT_CYCLES = 200000;
	localparam int unsigned DRAIN_CYCLES = 12;

	typedef struct packed {
		logic                command;
		logic [DAY_W-1:0]    base_day;
		logic [MONTH_W-1:0]  base_month;
		logic [YEAR_W-1:0]   base_year;
		logic [OFFSET_W-1:0] offset_days;
		logic [DAY_W-1:0]    other_day;
		logic [MONTH_W-1:0]  other_month;
		logic [YEAR_W-1:0]   other_year;
	} date_req_t;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               overflow;
	} date_res_t;

	localparam int unsigned REQ_BITS = $bits(date_req_t);

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic                command;
	logic [DAY_W-1:0]    base_day;
	logic [MONTH_W-1:0]  base_month;
	logic [YEAR_W-1:0]   base_year;
	logic [OFFSET_W-1:0] offset_days;
	logic [DAY_W-1:0]    other_day;
	logic [MONTH_W-1:0]  other_month;
	logic [YEAR_W-1:0]   other_year;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [DAY_W-1:0]    result_day;
	logic [MONTH_W-1:0]  result_month;
	logic [YEAR_W-1:0]   result_year;
	logic                overflow;

	date_res_t   expected_dates[$];
	bit          steady_stream;
	bit          failed;
	int unsigned cycle_count;

	calendar_date_add_days_core #(
		.MAX_YEAR(MAX_YEAR)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.base_day(base_day),
		.base_month(base_month),
		.base_year(base_year),
		.offset_days(offset_days),
		.other_day(other_day),
		.other_month(other_month),
		.other_year(other_year),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.result_day(result_day),
		.result_month(result_month),
		.result_year(result_year),
		.overflow(overflow)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		int unsigned len;
		case (m)
			2: len = FEB_COMMON + (((y % LEAP_PERIOD) == 0) ? 1 : 0);
			4, 6, 9, 11: len = 30;
			default: len = 31;
		endcase
		return len;
	endfunction

	function automatic int unsigned day_number(input logic [DAY_W-1:0] d,
			input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
		int unsigned mon;
		int unsigned yr;
		int unsigned prev;
		int unsigned count;
		mon = 32'(m);
		yr = 32'(y);
		if (mon < 1) mon = 1;
		if (mon > 12) mon = 12;
		if (yr < 1) yr = 1;
		prev = yr - 1;
		count = prev * DAYS_COMMON + prev / LEAP_PERIOD;
		for (int unsigned i = 1; i < mon; i++) count += month_length(i, 1);
		if (mon > 2 && (yr % LEAP_PERIOD) == 0) count += 1;
		return count + 32'(d);
	endfunction

	function automatic date_res_t date_of_day(input int unsigned count);
		int unsigned n0;
		int unsigned q;
		int unsigned r;
		int unsigned yoff;
		int unsigned yr;
		int unsigned doy;
		int unsigned mon;
		date_res_t res;
		if (count == 0) count = 1;
		n0 = count - 1;
		q = n0 / DAYS_PER_CYCLE;
		r = n0 % DAYS_PER_CYCLE;
		yoff = r / DAYS_COMMON;
		if (yoff > LEAP_PERIOD - 1) yoff = LEAP_PERIOD - 1;
		yr = q * LEAP_PERIOD + yoff + 1;
		doy = r - yoff * DAYS_COMMON;
		if (yr > MAX_YEAR) begin
			res.day = DAY_LAST;
			res.month = MONTH_DEC;
			res.year = YEAR_W'(MAX_YEAR);
			res.overflow = 1'b1;
		end else begin
			mon = 1;
			while (mon < 12 && doy >= month_length(mon, yr)) begin
				doy -= month_length(mon, yr);
				mon++;
			end
			res.day = DAY_W'(doy + 1);
			res.month = MONTH_W'(mon);
			res.year = YEAR_W'(yr);
			res.overflow = 1'b0;
		end
		return res;
	endfunction

	function automatic date_res_t predict_sum(input date_req_t w);
		int unsigned total;
		total = day_number(w.base_day, w.base_month, w.base_year);
		if (w.command == CMD_ADD_OFFSET) begin
			total += 32'(w.offset_days);
		end else begin
			total += day_number(w.other_day, w.other_month, w.other_year);
		end
		return date_of_day(total);
	endfunction

	function automatic date_req_t make_req(input int unsigned cmd, input int unsigned bd,
			input int unsigned bm, input int unsigned by, input int unsigned off,
			input int unsigned od, input int unsigned om, input int unsigned oy);
		date_req_t w;
		w.command = 1'(cmd);
		w.base_day = DAY_W'(bd);
		w.base_month = MONTH_W'(bm);
		w.base_year = YEAR_W'(by);
		w.offset_days = OFFSET_W'(off);
		w.other_day = DAY_W'(od);
		w.other_month = MONTH_W'(om);
		w.other_year = YEAR_W'(oy);
		return w;
	endfunction

	function automatic void pick_date(input int unsigned ymax, output logic [DAY_W-1:0] d,
			output logic [MONTH_W-1:0] m, output logic [YEAR_W-1:0] y);
		int unsigned yr;
		int unsigned mon;
		case ($urandom_range(9))
			0: yr = 1;
			1: yr = ymax;
			default: yr = $urandom_range(ymax, 1);
		endcase
		mon = $urandom_range(12, 1);
		y = YEAR_W'(yr);
		m = MONTH_W'(mon);
		d = DAY_W'($urandom_range(month_length(mon, yr), 1));
	endfunction

	// Most words carry valid dates; a tenth are raw bits to reach the odd encodings.
	function automatic date_req_t random_req();
		date_req_t w;
		int unsigned room;
		w = date_req_t'(REQ_BITS'({$urandom, $urandom}));
		if ($urandom_range(99) >= 10) begin
			pick_date(MAX_YEAR, w.base_day, w.base_month, w.base_year);
			if (w.command == CMD_ADD_OFFSET) begin
				case ($urandom_range(3))
					0: w.offset_days = OFFSET_W'($urandom_range(400));
					1: w.offset_days = OFFSET_W'($urandom_range(3000));
					default: w.offset_days = OFFSET_W'($urandom);
				endcase
			end else begin
				room = MAX_YEAR + 1 - 32'(w.base_year);
				pick_date(($urandom_range(1) == 0) ? room : MAX_YEAR,
					w.other_day, w.other_month, w.other_year);
			end
		end
		return w;
	endfunction

	task automatic send_word(input date_req_t w);
		while (!steady_stream && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		command <= w.command;
		base_day <= w.base_day;
		base_month <= w.base_month;
		base_year <= w.base_year;
		offset_days <= w.offset_days;
		other_day <= w.other_day;
		other_month <= w.other_month;
		other_year <= w.other_year;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_dates.push_back(predict_sum(w));
	endtask

	always @(posedge clk) begin
		rsp_stall <= !steady_stream && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		date_res_t exp_res;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_dates.size() == 0) begin
				$error("result word with no expected date: %0d/%0d/%0d overflow %0d",
					result_day, result_month, result_year, overflow);
				failed = 1'b1;
			end else begin
				exp_res = expected_dates.pop_front();
				if (result_day !== exp_res.day) begin
					$error("result_day: expected %0d, got %0d", exp_res.day, result_day);
					failed = 1'b1;
				end
				if (result_month !== exp_res.month) begin
					$error("result_month: expected %0d, got %0d", exp_res.month, result_month);
					failed = 1'b1;
				end
				if (result_year !== exp_res.year) begin
					$error("result_year: expected %0d, got %0d", exp_res.year, result_year);
					failed = 1'b1;
				end
				if (overflow !== exp_res.overflow) begin
					$error("overflow: expected %0d, got %0d", exp_res.overflow, overflow);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_year_boundaries();
		send_word(make_req(CMD_ADD_OFFSET, 31, 12, 2001, 0, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 31, 12, 2003, 1, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 28, 2, 2004, 1, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 28, 2, 2003, 1, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 31, 12, 2004, 0, 0, 0, 0));
		send_word(make_req(CMD_ADD_DATE, 1, 1, 1, 0, 31, 12, 3));
	endtask

	task automatic test_field_limits();
		send_word(make_req(CMD_ADD_OFFSET, 31, 12, 4095, 0, 31, 15, 4095));
		send_word(make_req(CMD_ADD_OFFSET, 31, 12, 4095, 65535, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 1, 1, 1, 65535, 0, 0, 0));
		send_word(make_req(CMD_ADD_DATE, 31, 12, 4095, 65535, 31, 12, 4095));
		send_word(make_req(CMD_ADD_DATE, 1, 1, 1, 0, 1, 1, 1));
		send_word(make_req(CMD_ADD_OFFSET, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_req(CMD_ADD_DATE, 0, 0, 0, 65535, 0, 0, 0));
	endtask

	task automatic test_field_normalization();
		send_word(make_req(CMD_ADD_OFFSET, 15, 0, 1999, 10, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 15, 13, 1999, 10, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 15, 14, 2000, 0, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 31, 15, 2000, 0, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 5, 6, 0, 0, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 31, 4, 2021, 0, 0, 0, 0));
		send_word(make_req(CMD_ADD_OFFSET, 0, 3, 2020, 0, 0, 0, 0));
		send_word(make_req(CMD_ADD_DATE, 10, 3, 100, 0, 31, 15, 0));
	endtask

	task automatic test_random_words(input int unsigned n);
		for (int unsigned i = 0; i < n; i++) send_word(random_req());
	endtask

	// Neither side idles here, so the pipeline runs full for a long stretch.
	task automatic test_back_to_back(input int unsigned n);
		steady_stream = 1'b1;
		test_random_words(n);
		steady_stream = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		rsp_stall = 1'b0;
		command = CMD_ADD_OFFSET;
		base_day = '0;
		base_month = '0;
		base_year = '0;
		offset_days = '0;
		other_day = '0;
		other_month = '0;
		other_year = '0;
		steady_stream = 1'b0;
		failed = 1'b0;
		cycle_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_year_boundaries();
		test_field_limits();
		test_field_normalization();
		test_random_words(700);
		test_back_to_back(300);
		test_random_words(750);
		req_valid <= 1'b0;
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
